>>> rtl/core/uuld_pkg.sv
// Shared types, constants and helper functions of the uudecode line decoder.
`default_nettype none

package uuld_pkg;

  // Character codes and limits of the line format.
  localparam logic [7:0] SPACE_CHAR     = 8'd32;
  localparam logic [7:0] ZERO_CHAR      = 8'd96;
  localparam logic [5:0] MAX_LINE_BYTES = 6'd45;
  localparam logic [7:0] DIGIT_MASK     = 8'd63;
  localparam logic [7:0] LEN_CHAR_MAX   = SPACE_CHAR + {2'b00, MAX_LINE_BYTES};
  localparam logic [7:0] DIGIT_CHAR_MAX = SPACE_CHAR + DIGIT_MASK;

  // Line status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  // Classification of one request by the front end.
  typedef enum logic [1:0] {
    KIND_LEN_OK   = 2'd0,
    KIND_LEN_BAD  = 2'd1,
    KIND_DIGIT    = 2'd2,
    KIND_CHAR_BAD = 2'd3
  } kind_t;

  // One classified request as it travels through the queue.
  typedef struct packed {
    kind_t      kind;
    logic [5:0] value;  // line length or 6-bit digit
    logic [5:0] chars;  // expected digit characters for a length request
  } entry_t;

  // Number of digit characters for a line length: (len * 4 + 2) / 3.
  // The divide by three is a multiply by 171 and a shift by nine, which is
  // exact for all sums below 256.
  function automatic logic [5:0] char_count(input logic [5:0] len);
    logic [7:0]  sum;
    logic [15:0] prod;
    sum  = {len, 2'b00} + 8'd2;
    prod = 16'(sum) * 16'd171;
    return prod[14:9];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/uuld_if.sv
// Valid/ready channel interfaces for the character input and the result output.
`default_nettype none

interface uuld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       line_start;

  modport source (output valid, output character, output line_start, input ready);
  modport sink   (input valid, input character, input line_start, output ready);
endinterface

interface uuld_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] data_byte;
  logic       line_done;
  logic [1:0] status;
  logic [5:0] byte_count;

  modport source (output valid, output byte_valid, output data_byte, output line_done,
                  output status, output byte_count, input ready);
  modport sink   (input valid, input byte_valid, input data_byte, input line_done,
                  input status, input byte_count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/uuld_front.sv
// Front end: accepts characters and classifies them into queue entries.
`default_nettype none

module uuld_front (
  uuld_in_if.sink          in_chan,
  input  wire logic        q_ready,
  output logic             push_valid,
  output uuld_pkg::entry_t push_entry
);

  logic [7:0] offset;

  assign offset         = in_chan.character - uuld_pkg::SPACE_CHAR;
  assign in_chan.ready  = q_ready;
  assign push_valid     = in_chan.valid;

  // Sort the character into length, digit or error, and take its value.
  always_comb begin
    push_entry.kind  = uuld_pkg::KIND_CHAR_BAD;
    push_entry.value = 6'd0;
    if (in_chan.line_start) begin
      if (in_chan.character == uuld_pkg::ZERO_CHAR) begin
        push_entry.kind = uuld_pkg::KIND_LEN_OK;
      end else if (in_chan.character >= uuld_pkg::SPACE_CHAR &&
                   in_chan.character <= uuld_pkg::LEN_CHAR_MAX) begin
        push_entry.kind  = uuld_pkg::KIND_LEN_OK;
        push_entry.value = offset[5:0];
      end else begin
        push_entry.kind = uuld_pkg::KIND_LEN_BAD;
      end
    end else begin
      if (in_chan.character == uuld_pkg::ZERO_CHAR) begin
        push_entry.kind = uuld_pkg::KIND_DIGIT;
      end else if (in_chan.character >= uuld_pkg::SPACE_CHAR &&
                   in_chan.character <= uuld_pkg::DIGIT_CHAR_MAX) begin
        push_entry.kind  = uuld_pkg::KIND_DIGIT;
        push_entry.value = offset[5:0];
      end
    end
    push_entry.chars = uuld_pkg::char_count(push_entry.value);
  end

endmodule

`default_nettype wire

>>> rtl/core/uuld_queue.sv
// Two-entry queue between the front end and the back end.
`default_nettype none

module uuld_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  input  wire uuld_pkg::entry_t push_entry,
  output logic                  push_ready,
  input  wire logic             pop,
  output logic                  pop_valid,
  output uuld_pkg::entry_t      pop_entry
);

  uuld_pkg::entry_t entries_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_entry  = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!do_push && pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/uuld_back.sv
// Back end: line state, digit combining and the registered result output.
`default_nettype none

module uuld_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire uuld_pkg::entry_t q_entry,
  output logic                  q_pop,
  uuld_out_if.source            out_chan
);

  // Line state.
  logic       in_line_r, in_line_nxt;
  logic [5:0] chars_left_r, chars_left_nxt;
  logic [1:0] group_pos_r, group_pos_nxt;
  logic [5:0] held_digit_r, held_digit_nxt;
  logic [5:0] bytes_done_r, bytes_done_nxt;
  logic [5:0] expected_r, expected_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic       byte_valid_r;
  logic [7:0] data_byte_r;
  logic       line_done_r;
  logic [1:0] status_r;
  logic [5:0] byte_count_r;

  // Result of the request at the queue head.
  logic       res_valid;
  logic       res_byte_valid;
  logic [7:0] res_data_byte;
  logic       res_line_done;
  uuld_pkg::status_t res_status;
  logic [5:0] res_byte_count;

  logic       can_load;
  logic [5:0] digit;

  assign can_load = !out_valid_r || out_chan.ready;
  assign q_pop    = q_valid && can_load;
  assign digit    = q_entry.value;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.byte_valid = byte_valid_r;
  assign out_chan.data_byte  = data_byte_r;
  assign out_chan.line_done  = line_done_r;
  assign out_chan.status     = status_r;
  assign out_chan.byte_count = byte_count_r;

  // Carry out one request and compute the next line state.
  always_comb begin
    in_line_nxt    = in_line_r;
    chars_left_nxt = chars_left_r;
    group_pos_nxt  = group_pos_r;
    held_digit_nxt = held_digit_r;
    bytes_done_nxt = bytes_done_r;
    expected_nxt   = expected_r;
    res_valid      = 1'b0;
    res_byte_valid = 1'b0;
    res_data_byte  = 8'd0;
    res_line_done  = 1'b0;
    res_status     = uuld_pkg::ST_OK;
    res_byte_count = 6'd0;
    unique case (q_entry.kind) inside
      uuld_pkg::KIND_LEN_OK, uuld_pkg::KIND_LEN_BAD: begin
        in_line_nxt    = 1'b0;
        chars_left_nxt = 6'd0;
        group_pos_nxt  = 2'd0;
        held_digit_nxt = 6'd0;
        bytes_done_nxt = 6'd0;
        expected_nxt   = 6'd0;
        if (q_entry.kind == uuld_pkg::KIND_LEN_BAD) begin
          res_valid     = 1'b1;
          res_line_done = 1'b1;
          res_status    = uuld_pkg::ST_BAD_LEN;
        end else if (q_entry.value == 6'd0) begin
          res_valid     = 1'b1;
          res_line_done = 1'b1;
        end else begin
          in_line_nxt    = 1'b1;
          expected_nxt   = q_entry.value;
          chars_left_nxt = q_entry.chars;
        end
      end
      uuld_pkg::KIND_CHAR_BAD: begin
        if (in_line_r) begin
          in_line_nxt    = 1'b0;
          res_valid      = 1'b1;
          res_line_done  = 1'b1;
          res_status     = uuld_pkg::ST_BAD_CHAR;
          res_byte_count = bytes_done_r;
        end
      end
      default: begin
        if (in_line_r) begin
          // Combine the held digit with the new one.
          case (group_pos_r)
            2'd1: begin
              res_byte_valid = 1'b1;
              res_data_byte  = {held_digit_r, digit[5:4]};
            end
            2'd2: begin
              res_byte_valid = 1'b1;
              res_data_byte  = {held_digit_r[3:0], digit[5:2]};
            end
            2'd3: begin
              res_byte_valid = 1'b1;
              res_data_byte  = {held_digit_r[1:0], digit};
            end
            default: begin
              res_byte_valid = 1'b0;
            end
          endcase
          held_digit_nxt = digit;
          group_pos_nxt  = group_pos_r + 2'd1;
          bytes_done_nxt = bytes_done_r + {5'd0, res_byte_valid};
          chars_left_nxt = chars_left_r - 6'd1;
          res_valid      = res_byte_valid;
          if (chars_left_nxt == 6'd0) begin
            in_line_nxt    = 1'b0;
            res_valid      = 1'b1;
            res_line_done  = 1'b1;
            res_byte_count = bytes_done_nxt;
            res_status     = (bytes_done_nxt == expected_r) ? uuld_pkg::ST_OK
                                                            : uuld_pkg::ST_MISMATCH;
          end
        end
      end
    endcase
  end

  // The output register is free or is being emptied this cycle.
  always_comb begin
    if (q_pop) begin
      out_valid_nxt = res_valid;
    end else begin
      out_valid_nxt = out_valid_r && !out_chan.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_line_r    <= 1'b0;
      chars_left_r <= 6'd0;
      group_pos_r  <= 2'd0;
      held_digit_r <= 6'd0;
      bytes_done_r <= 6'd0;
      expected_r   <= 6'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        in_line_r    <= in_line_nxt;
        chars_left_r <= chars_left_nxt;
        group_pos_r  <= group_pos_nxt;
        held_digit_r <= held_digit_nxt;
        bytes_done_r <= bytes_done_nxt;
        expected_r   <= expected_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      byte_valid_r <= res_byte_valid;
      data_byte_r  <= res_data_byte;
      line_done_r  <= res_line_done;
      status_r     <= res_status;
      byte_count_r <= res_byte_count;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/uudecode_line_decoder.sv
// Top level of the uudecode line decoder.
//
// Usage: characters of a uuencoded line enter on in_chan, one per request.
// A request with line_start set carries the length character; the digit
// characters follow. Each result on out_chan carries a decoded byte
// (byte_valid), the end of a line (line_done with status and byte_count),
// or both. Digit characters outside an open line produce no result.
// Path: with the queue empty, an accepted character is written into the
// two-entry queue and then loaded into the output register of the back
// end, from which its result is offered on out_chan. The front end is
// combinational.
// Throughput: one character per cycle, sustained while out_chan takes
// results; the back end carries out one queue entry each cycle.
// Reset: rst_n clears the queue, the line state and the output valid flag;
// no line is open after reset.
// Stall: while out_chan.ready is low the result holds, the back end stops,
// and in_chan.ready falls once the two queue entries are full.
`default_nettype none

module uudecode_line_decoder (
  input  wire logic  clk,
  input  wire logic  rst_n,
  uuld_in_if.sink    in_chan,
  uuld_out_if.source out_chan
);

  logic             push_valid;
  logic             push_ready;
  uuld_pkg::entry_t push_entry;
  logic             q_valid;
  logic             q_pop;
  uuld_pkg::entry_t q_entry;

  uuld_front u_front (
    .in_chan    (in_chan),
    .q_ready    (push_ready),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  uuld_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry)
  );

  uuld_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

>>> rtl/core/uuld_checker.sv
// Port-level checks on the result channel of the uudecode line decoder.
`default_nettype none

module uuld_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_byte_valid,
  input wire logic       out_line_done,
  input wire logic [1:0] out_status,
  input wire logic [5:0] out_byte_count
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Every result carries a byte, an end of line, or both.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_line_done)
    else $error("empty result");

  // A plain byte result has no status or count.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_line_done |-> out_status == uuld_pkg::ST_OK &&
                                    out_byte_count == 6'd0)
    else $error("status or count outside line end");

  // A bad length ends a line without bytes.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_done && out_status == uuld_pkg::ST_BAD_LEN |->
      !out_byte_valid && out_byte_count == 6'd0)
    else $error("bad length with bytes");

  // No line holds more than the maximum byte count.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_count <= uuld_pkg::MAX_LINE_BYTES)
    else $error("byte count too large");

endmodule

bind uudecode_line_decoder uuld_checker u_uuld_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_byte_valid (out_chan.byte_valid),
  .out_line_done  (out_chan.line_done),
  .out_status     (out_chan.status),
  .out_byte_count (out_chan.byte_count)
);

`default_nettype wire
